### hdl/cts_pkg.sv
// Shared constants, codes and controller/datapath interface types for tournament selection.
package cts_pkg;

  localparam int DEF_MAX_POP = 256;

  localparam int ENERGY_W   = 32;
  localparam int IDX_W      = 8;
  localparam int POP_W      = 9;
  localparam int CAP_W      = 3;
  localparam int CNT_W      = 3;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_CAP  = 1'd1;

  localparam logic [POP_W-1:0] POP_RESET = 9'd256;
  localparam logic [CAP_W-1:0] CAP_RESET = 3'd4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_TOURNEY = 1'b1;

  typedef struct packed {
    logic clear;   // zero one use count of the power-up sweep
    logic load;    // store energy and clear count of the request's member
    logic start;   // capture starts, begin first probe
    logic probe;   // issue one count read
    logic second;  // probing for the second contestant
    logic take1;   // first contestant found, restart probe at second start
    logic none;    // nobody eligible
    logic take2;   // second contestant found
    logic ride;    // no distinct second contestant
    logic rd1;     // read first energy, bump first count
    logic rd2;     // read second energy, bump second count
    logic cmp;     // pick the winner
    logic emit;    // load the output register
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic exhausted;
    logic out_free;
  } status_t;

endpackage

### hdl/cts_ram.sv
// Generic simple dual-port RAM with registered read.
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/cts_ctrl.sv
// Controller state machine: sequences clearing, probing, energy reads and result hand-off.
module cts_ctrl import cts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PROBE1 = 3'd2;
  localparam logic [2:0] S_PROBE2 = 3'd3;
  localparam logic [2:0] S_RD1    = 3'd4;
  localparam logic [2:0] S_RD2    = 3'd5;
  localparam logic [2:0] S_CMP    = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_PROBE1;
          end
        end
      end
      S_PROBE1: begin
        cmd.probe = !(status.hit || status.exhausted);
        if (status.hit) begin
          cmd.take1  = 1'b1;
          state_next = S_PROBE2;
        end else if (status.exhausted) begin
          cmd.none   = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_PROBE2: begin
        cmd.second = 1'b1;
        cmd.probe  = !(status.hit || status.exhausted);
        if (status.hit) begin
          cmd.take2  = 1'b1;
          state_next = S_RD1;
        end else if (status.exhausted) begin
          cmd.ride   = 1'b1;
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd2    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/cts_dp.sv
// Datapath: config registers, energy and use-count RAMs, probe pointer, compare and output register.
module cts_dp import cts_pkg::*; #(
  parameter int MAX_POP = DEF_MAX_POP
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user
);

  localparam int PW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int NW = (PW + 1 > POP_W) ? PW + 1 : POP_W;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  // configuration
  logic [POP_W-1:0] pop_size;
  logic [CAP_W-1:0] use_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size <= POP_RESET;
      use_cap  <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POP_SIZE: pop_size <= cfg_data[POP_W-1:0];
        REG_USE_CAP:  use_cap  <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [IDX_W-1:0]    load_index;
  logic [ENERGY_W-1:0] energy_value;
  logic [IDX_W-1:0]    first_start;
  logic [IDX_W-1:0]    second_start;

  assign load_index   = in_data[7:0];
  assign energy_value = in_data[39:8];
  assign first_start  = in_data[47:40];
  assign second_start = in_data[55:48];

  // effective population and clamped starts
  logic [NW-1:0] pop_ext;
  logic [NW-1:0] n_lim;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_last;
  logic [PW-1:0] last_idx;
  logic [PW-1:0] s1_clamp;
  logic [PW-1:0] s2_clamp;
  logic          load_ok;

  assign pop_ext  = NW'(pop_size);
  assign n_lim    = (pop_ext > NW'(MAX_POP)) ? NW'(MAX_POP) : pop_ext;
  assign n_eff    = (n_lim == '0) ? NW'(1) : n_lim;
  assign n_last   = n_eff - NW'(1);
  assign last_idx = PW'(n_last);
  assign s1_clamp = (NW'(first_start) >= n_eff) ? last_idx : PW'(first_start);
  assign s2_clamp = (NW'(second_start) >= n_eff) ? last_idx : PW'(second_start);
  assign load_ok  = NW'(load_index) < NW'(MAX_POP);

  // contestants
  logic [PW-1:0]       m1;
  logic [PW-1:0]       m2;
  logic [CNT_W-1:0]    c1;
  logic [CNT_W-1:0]    c2;
  logic                ride;
  logic                nocand;
  logic [PW-1:0]       winner;
  logic [ENERGY_W-1:0] e1;
  logic [ENERGY_W-1:0] e_rdata;

  // probe state
  logic [PW-1:0]    ptr;
  logic [PW-1:0]    s2_reg;
  logic [PW-1:0]    rd_addr;
  logic             pend;
  logic [NW-1:0]    chk;
  logic             issue;
  logic [CNT_W-1:0] cnt_rdata;
  logic             cand;

  assign issue = cmd.probe;
  assign cand  = pend && (cnt_rdata < use_cap) && !(cmd.second && rd_addr == m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr    <= s1_clamp;
      s2_reg <= s2_clamp;
    end else if (cmd.take1) begin
      ptr <= s2_reg;
    end else if (issue) begin
      ptr <= (ptr == last_idx) ? '0 : ptr + PW'(1);
    end
    if (issue) begin
      rd_addr <= ptr;
    end
    if (cmd.start || cmd.take1) begin
      chk <= '0;
    end else if (pend && !cand) begin
      chk <= chk + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nocand <= 1'b0;
    end else if (cmd.none) begin
      nocand <= 1'b1;
    end
    if (cmd.take1) begin
      m1 <= rd_addr;
      c1 <= cnt_rdata;
    end
    if (cmd.take2) begin
      m2   <= rd_addr;
      c2   <= cnt_rdata;
      ride <= 1'b0;
    end else if (cmd.ride) begin
      m2   <= m1;
      c2   <= c1;
      ride <= 1'b1;
    end
    if (cmd.rd2) begin
      e1 <= e_rdata;
    end
    if (cmd.cmp) begin
      winner <= ($signed(e1) >= $signed(e_rdata)) ? m1 : m2;
    end
  end

  // use-count RAM write port
  logic [PW-1:0]    clr_addr;
  logic             cnt_we;
  logic [PW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;

  assign status.clear_last = (clr_addr == PW'(MAX_POP - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + PW'(1);
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr;
    cnt_wdata = '0;
    if (cmd.clear) begin
      cnt_we = 1'b1;
    end else if (cmd.load) begin
      cnt_we    = load_ok;
      cnt_waddr = PW'(load_index);
    end else if (cmd.rd1) begin
      // a free ride uses the first member twice
      cnt_we    = 1'b1;
      cnt_waddr = m1;
      cnt_wdata = ride ? sat_inc(sat_inc(c1)) : sat_inc(c1);
    end else if (cmd.rd2) begin
      cnt_we    = !ride;
      cnt_waddr = m2;
      cnt_wdata = sat_inc(c2);
    end
  end

  cts_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_POP)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (issue),
    .raddr (ptr),
    .rdata (cnt_rdata)
  );

  cts_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (MAX_POP)
  ) u_energy_ram (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (PW'(load_index)),
    .wdata (energy_value),
    .re    (cmd.rd1 || cmd.rd2),
    .raddr (cmd.rd1 ? m1 : m2),
    .rdata (e_rdata)
  );

  // output register
  assign status.hit       = cand;
  assign status.exhausted = pend && !cand && (chk == n_last);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (nocand) begin
        out_data <= '0;
        out_user <= 2'b10;
      end else begin
        out_data <= {IDX_W'(m2), IDX_W'(m1), IDX_W'(winner)};
        out_user <= {1'b0, ride};
      end
    end
  end

endmodule

### hdl/capped_tournament_selection_unit.sv
// A load request is written when it is accepted and the unit stays idle. A tournament runs
// two probe searches, each probing at most the effective population n, then reads both
// energies, compares and loads the result register; with nobody eligible it goes to the result.
// Throughput: one request at a time; s_axis_tready returns once the result register loads.
// Reset: synchronous; afterwards a sweep over all MAX_POP entries zeroes the use counts with
// s_axis_tready low. Configuration writes are taken during the sweep.
module capped_tournament_selection_unit import cts_pkg::*; #(
  parameter int MAX_POP = DEF_MAX_POP
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // load_index[7:0], energy_value[39:8], first_start[47:40], second_start[55:48]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // winner_index[7:0], first_mate[15:8], second_mate[23:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // free_ride[0], no_candidate[1]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser[0]),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cts_dp #(
    .MAX_POP (MAX_POP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

### hdl/cts_checker.sv
// Port-level checker for the tournament selection unit, bound to the top level.
module cts_checker import cts_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // reset starts the count-clearing sweep, no requests taken
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("request accepted right after reset");

  a_nocand_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("no-candidate result carries data");

  a_ride_same: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[15:8] == m_axis_tdata[23:16] && m_axis_tdata[7:0] == m_axis_tdata[15:8])
    else $error("free ride with distinct contestants");

  a_winner_member: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |->
      m_axis_tdata[7:0] == m_axis_tdata[15:8] || m_axis_tdata[7:0] == m_axis_tdata[23:16])
    else $error("winner is not a contestant");

endmodule

bind capped_tournament_selection_unit cts_checker u_cts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
